// ----- src/b2d_pkg.sv -----
// Package for the binary to decimal ASCII converter.
// Holds the widths, digit counts and shared types. It has no dependencies.
package b2d_pkg;

  // Width of the number field on the input channel.
  localparam int unsigned NUMBER_W    = 64;
  // Bits of the number that take part in the conversion.
  localparam int unsigned VALUE_WIDTH = 64;
  // Largest count of decimal digits that are kept and sent.
  localparam int unsigned MAX_DIGITS  = 20;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned BCD_W   = DIGIT_W * MAX_DIGITS;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned DIG_CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // Status of the conversion unit, seen by the top level and the digit sender.
  typedef struct packed {
    logic busy;  // An item is being converted or its result is about to be handed on.
    logic done;  // One-cycle pulse: the BCD result and overflow flag are final.
    logic ovf;   // The value needs more than MAX_DIGITS digits.
  } conv_stat_t;

endpackage

// ----- src/b2d_if.sv -----
// Handshake interfaces for the binary to decimal ASCII converter.
// Depends on b2d_pkg for the field widths.
interface b2d_in_if;
  logic                          valid;
  logic                          ready;
  logic [b2d_pkg::NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface b2d_out_if;
  logic                        valid;
  logic                        ready;
  logic [b2d_pkg::CHAR_W-1:0] digit_char;
  logic                        last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- src/b2d_dabble_step.sv -----
// One shift-and-add-3 step over the whole BCD register.
// Depends on b2d_pkg for the digit count and widths.
module b2d_dabble_step (
  input  logic [b2d_pkg::BCD_W-1:0] bcd_i,
  input  logic                      bit_i,
  output logic [b2d_pkg::BCD_W-1:0] bcd_o,
  output logic                      carry_o
);

  logic [b2d_pkg::BCD_W-1:0] adj;

  // Every digit of five or more is corrected by three before the doubling.
  always_comb begin
    for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
      if (bcd_i[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] >= b2d_pkg::DIGIT_W'(5)) begin
        adj[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
            bcd_i[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] + b2d_pkg::DIGIT_W'(3);
      end else begin
        adj[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
            bcd_i[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W];
      end
    end
  end

  assign bcd_o   = {adj[b2d_pkg::BCD_W-2:0], bit_i};
  assign carry_o = adj[b2d_pkg::BCD_W-1];

endmodule

// ----- src/b2d_conv.sv -----
// Bit-serial double dabble sequencer: one input bit per cycle through the shared step.
// Depends on b2d_pkg and b2d_dabble_step.
module b2d_conv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [b2d_pkg::VALUE_WIDTH-1:0] value_i,
  output b2d_pkg::conv_stat_t              stat_o,
  output logic [b2d_pkg::BCD_W-1:0]        bcd_o
);

  logic                             run_q, run_d;
  logic                             done_q, done_d;
  logic                             ovf_q, ovf_d;
  logic [b2d_pkg::BIT_CNT_W-1:0]    cnt_q, cnt_d;
  logic [b2d_pkg::VALUE_WIDTH-1:0]  val_q, val_d;
  logic [b2d_pkg::BCD_W-1:0]        bcd_q, bcd_d;
  logic [b2d_pkg::BCD_W-1:0]        step_bcd;
  logic                             step_carry;

  b2d_dabble_step u_step (
    .bcd_i   (bcd_q),
    .bit_i   (val_q[b2d_pkg::VALUE_WIDTH-1]),
    .bcd_o   (step_bcd),
    .carry_o (step_carry)
  );

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      run_d = 1'b1;
      ovf_d = 1'b0;
      cnt_d = b2d_pkg::BIT_CNT_W'(b2d_pkg::VALUE_WIDTH - 1);
      val_d = value_i;
      bcd_d = '0;
    end else if (run_q) begin
      // A bit pushed out of the top digit means the value does not fit.
      bcd_d = step_bcd;
      ovf_d = ovf_q | step_carry;
      val_d = val_q << 1;
      cnt_d = cnt_q - b2d_pkg::BIT_CNT_W'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    cnt_q <= cnt_d;
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.busy = run_q | done_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign bcd_o       = bcd_q;

endmodule

// ----- src/b2d_emit.sv -----
// Digit sender: drops leading zeros (not for a truncated value), then sends one ASCII digit per item.
// Depends on b2d_pkg and the b2d_out_if interface.
module b2d_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      ovf_i,
  input  logic [b2d_pkg::BCD_W-1:0] bcd_i,
  output logic                      busy_o,
  b2d_out_if.source                 out
);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_SKIP = 3'b010,
    E_SEND = 3'b100
  } emit_state_e;

  emit_state_e                    state_q, state_d;
  logic [b2d_pkg::BCD_W-1:0]      bcd_q, bcd_d;
  logic [b2d_pkg::DIG_CNT_W-1:0]  rem_q, rem_d;
  logic [b2d_pkg::DIGIT_W-1:0]    top_digit;
  logic                           is_last;

  assign top_digit = bcd_q[b2d_pkg::BCD_W-1 -: b2d_pkg::DIGIT_W];
  assign is_last   = (rem_q == b2d_pkg::DIG_CNT_W'(1));

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    rem_d   = rem_q;
    unique case (state_q)
      E_IDLE: begin
        if (load_i) begin
          bcd_d = bcd_i;
          rem_d = b2d_pkg::DIG_CNT_W'(b2d_pkg::MAX_DIGITS);
          // A truncated value is sent with all its positions.
          state_d = ovf_i ? E_SEND : E_SKIP;
        end
      end
      E_SKIP: begin
        if ((top_digit == '0) && !is_last) begin
          bcd_d = bcd_q << b2d_pkg::DIGIT_W;
          rem_d = rem_q - b2d_pkg::DIG_CNT_W'(1);
        end else begin
          state_d = E_SEND;
        end
      end
      E_SEND: begin
        if (out.ready) begin
          bcd_d = bcd_q << b2d_pkg::DIGIT_W;
          rem_d = rem_q - b2d_pkg::DIG_CNT_W'(1);
          if (is_last) begin
            state_d = E_IDLE;
          end
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    rem_q <= rem_d;
  end

  assign out.valid      = (state_q == E_SEND);
  assign out.digit_char = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(top_digit);
  assign out.last       = is_last;
  assign busy_o         = (state_q != E_IDLE);

endmodule

// ----- src/binary_to_decimal_ascii_top.sv -----
// Top level of the binary to decimal ASCII converter.
// Depends on b2d_pkg, b2d_if, b2d_conv and b2d_emit.
//
// Usage:
//   num_i carries one unsigned 64-bit number per item. dig_o carries the
//   decimal text of that number, one ASCII digit per item, most significant
//   digit first, with leading zeros dropped and last set on the final digit.
//   Zero gives the single digit '0'. A number that needs more than
//   MAX_DIGITS digits is sent as its MAX_DIGITS low digits, zeros included.
//
// Flow:
//   After an item is accepted, the conversion takes one input bit per cycle
//   through the shared add-3 and shift unit, and the done pulse then hands
//   the result over. The sender walks all MAX_DIGITS positions: it drops
//   the leading zeros one at a time, then starts sending, and sends each
//   digit when the receiver takes it. num_i reopens only after the last
//   digit is taken, so a new number is not accepted before the previous one
//   has been fully sent.
//
// Reset and stalls:
//   Reset clears the sequencers; no partial result survives it. num_i.ready
//   is high only while nothing is in flight. A stalled receiver holds the
//   current digit on dig_o and the block simply waits.
module binary_to_decimal_ascii_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  b2d_in_if.sink    num_i,
  b2d_out_if.source dig_o
);

  b2d_pkg::conv_stat_t       conv_stat;
  logic [b2d_pkg::BCD_W-1:0] conv_bcd;
  logic                      emit_busy;
  logic                      accept;

  // One number at a time: the input opens only when both units are free.
  assign num_i.ready = !conv_stat.busy && !emit_busy;
  assign accept      = num_i.valid && num_i.ready;

  // Conversion unit; only the low VALUE_WIDTH bits of the number take part.
  b2d_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (num_i.number[b2d_pkg::VALUE_WIDTH-1:0]),
    .stat_o  (conv_stat),
    .bcd_o   (conv_bcd)
  );

  // The finished BCD word is loaded into the sender in the pulse cycle; the
  // sender turns busy on the next edge, so the input stays closed throughout.
  b2d_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (conv_stat.done),
    .ovf_i  (conv_stat.ovf),
    .bcd_i  (conv_bcd),
    .busy_o (emit_busy),
    .out    (dig_o)
  );

endmodule
